// File: src/keyboard_scancode_decoder_core_macros.svh
// Assertion macros for the keyboard scancode decoder.
// Each macro checks one implication on the rising clock edge, disabled in reset.
`ifndef KEYBOARD_SCANCODE_DECODER_CORE_MACROS_SVH
`define KEYBOARD_SCANCODE_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define KBD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kbd: same-cycle check failed");
// Next-cycle implication
`define KBD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kbd: next-cycle check failed");
`else
`define KBD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KBD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: src/kbd_pkg.sv
`timescale 1ns / 1ps

package kbd_pkg;

  // Key map geometry
  localparam int KEY_COUNT  = 128;
  localparam int KEY_ADDR_W = $clog2(KEY_COUNT);

  // Fixed field widths
  localparam int CODE_W    = 7;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int MOD_COUNT = 4;

  // Item opcodes
  typedef enum logic [OP_W-1:0] {
    OP_EVENT = 2'd0,
    OP_POLL  = 2'd1,
    OP_TEST  = 2'd2
  } op_t;

  // Configuration register indexes (also modifier slots)
  localparam logic [CFG_IDX_W-1:0] CFG_ALT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CTRL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LSHIFT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RSHIFT = 2'd3;

  // Modifier scancodes after reset, slot 0 in the low bits
  localparam logic [MOD_COUNT-1:0][CODE_W-1:0] MOD_RESET = {7'd54, 7'd42, 7'd29, 7'd56};

  // Input item
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CODE_W-1:0] scancode;
    logic              pressed;
  } kbd_in_t;

  // Result item
  typedef struct packed {
    logic              key_valid;
    logic              is_char;
    logic [CODE_W-1:0] char_code;
    logic [CODE_W-1:0] key_code;
    logic              alt_held;
    logic              ctrl_held;
    logic              shift_held;
    logic              key_is_down;
  } kbd_out_t;

  // Held-map RAM access
  typedef struct packed {
    logic                  we;
    logic [KEY_ADDR_W-1:0] waddr;
    logic                  wdata;
    logic                  re;
    logic [KEY_ADDR_W-1:0] raddr;
  } kbd_ram_req_t;

  // Key state status toward the handshake logic
  typedef struct packed {
    logic clearing;
    logic refreshing;
  } kbd_status_t;

  // Translation tables, codes at or above TAB_DEPTH have no character
  localparam int TAB_DEPTH  = 64;
  localparam int TAB_ADDR_W = $clog2(TAB_DEPTH);

  localparam logic [CODE_W-1:0] PLAIN_TAB [TAB_DEPTH] = '{
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h00, 7'h00,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h00, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h5C, 7'h00, 7'h3C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam logic [CODE_W-1:0] SHIFT_TAB [TAB_DEPTH] = '{
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h00, 7'h00,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h00, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7C, 7'h00, 7'h3E, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // Look up the character for a key, zero when there is none
  function automatic logic [CODE_W-1:0] char_lookup(input logic [CODE_W-1:0] code,
                                                     input logic shift);
    logic [CODE_W-1:0] ch;
    ch = '0;
    if (code < CODE_W'(TAB_DEPTH)) begin
      ch = shift ? SHIFT_TAB[code[TAB_ADDR_W-1:0]] : PLAIN_TAB[code[TAB_ADDR_W-1:0]];
    end
    return ch;
  endfunction

  // True when a scancode has an entry in the key map
  function automatic logic key_in_range(input logic [CODE_W-1:0] code);
    return 32'(code) < 32'(KEY_COUNT);
  endfunction

  // Key map address of a scancode
  function automatic logic [KEY_ADDR_W-1:0] key_addr(input logic [CODE_W-1:0] code);
    return KEY_ADDR_W'(code);
  endfunction

endpackage

// File: src/keyboard_scancode_decoder_core.sv
`timescale 1ns / 1ps
// A result passes through the map read (stage 1) and then the output register before it is valid.
// Throughput: one item per cycle while in_stall is low, set by the single read port of the held-map RAM.
// A configuration write stalls input while it is pending and while the modifier flag is reread.
// Reset: synchronous, active low; afterwards a clearing pass zeroes all KEY_COUNT (128) entries
// of the held map, during which in_stall is high; configuration writes are taken.
`include "keyboard_scancode_decoder_core_macros.svh"

module keyboard_scancode_decoder_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  kbd_pkg::kbd_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output kbd_pkg::kbd_out_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kbd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kbd_pkg::CODE_W-1:0]        cfg_data
);

  kbd_pkg::kbd_ram_req_t ram_req;
  kbd_pkg::kbd_out_t     poll_res;
  kbd_pkg::kbd_status_t  status;
  logic                  rd_bit;
  logic                  in_acc;
  logic                  cfg_we;
  logic                  advance;

  // Stage 1: item waiting for the map read
  logic                  s1_valid_r, s1_valid_nxt;
  kbd_pkg::kbd_out_t     s1_res_r, s1_res_nxt;
  logic                  s1_test_r, s1_test_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  kbd_pkg::kbd_out_t     out_data_r, out_data_nxt;

  // Terms for the checks below
  logic                  poll_rep;
  logic                  out_char;
  logic                  char_clean;

  // Handshakes
  assign advance   = !out_valid_r || !out_stall;
  assign cfg_ready = !s1_valid_r && !status.refreshing;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_stall  = status.clearing || status.refreshing || cfg_valid ||
                     (s1_valid_r && !advance);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  kbd_key_state u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (in_acc),
    .item     (in_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_index),
    .cfg_val  (cfg_data),
    .rd_bit   (rd_bit),
    .ram_req  (ram_req),
    .poll_res (poll_res),
    .status   (status)
  );

  kbd_ram #(
    .WIDTH (1),
    .DEPTH (kbd_pkg::KEY_COUNT)
  ) u_held_map (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rd_bit)
  );

  // Load stage 1 on accept, drop it when it moves on
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_res_nxt   = s1_res_r;
    s1_test_nxt  = s1_test_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
      s1_res_nxt   = (in_data.op == kbd_pkg::OP_POLL) ? poll_res : '0;
      s1_test_nxt  = (in_data.op == kbd_pkg::OP_TEST) &&
                     kbd_pkg::key_in_range(in_data.scancode);
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Merge the key test answer into the result and hold it while stalled
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (advance) begin
      out_valid_nxt            = s1_valid_r;
      out_data_nxt             = s1_res_r;
      out_data_nxt.key_is_down = s1_test_r && rd_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_res_r   <= s1_res_nxt;
    s1_test_r  <= s1_test_nxt;
    out_data_r <= out_data_nxt;
  end

  assign poll_rep   = in_acc && (in_data.op == kbd_pkg::OP_POLL) && poll_res.key_valid;
  assign out_char   = out_valid_r && out_data_r.is_char;
  assign char_clean = out_data_r.key_valid && !out_data_r.alt_held && !out_data_r.ctrl_held;

  `KBD_ASSERT_NXT(a_cfg_refresh_stall, clk, rst_n, cfg_valid && cfg_ready, !in_acc)
  `KBD_ASSERT_NXT(a_poll_once, clk, rst_n, poll_rep, !poll_res.key_valid)
  `KBD_ASSERT_NXT(a_rdata_hold, clk, rst_n, s1_valid_r && !advance, $stable(rd_bit))
  `KBD_ASSERT_IMP(a_char_no_mods, clk, rst_n, out_char, char_clean)

endmodule

// File: src/kbd_ram.sv
`timescale 1ns / 1ps

module kbd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read with old data on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/kbd_key_state.sv
`timescale 1ns / 1ps

module kbd_key_state (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                acc,
  input  kbd_pkg::kbd_in_t                    item,
  input  logic                                cfg_we,
  input  logic [kbd_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [kbd_pkg::CODE_W-1:0]          cfg_val,
  input  logic                                rd_bit,
  output kbd_pkg::kbd_ram_req_t               ram_req,
  output kbd_pkg::kbd_out_t                   poll_res,
  output kbd_pkg::kbd_status_t                status
);

  // Held-map clearing pass
  logic                              clr_busy_r, clr_busy_nxt;
  logic [kbd_pkg::KEY_ADDR_W-1:0]    clr_idx_r, clr_idx_nxt;

  // Modifier scancodes and their held flags
  logic [kbd_pkg::MOD_COUNT-1:0][kbd_pkg::CODE_W-1:0] mod_code_r, mod_code_nxt;
  logic [kbd_pkg::MOD_COUNT-1:0]                      mod_held_r, mod_held_nxt;

  // Last pressed key
  logic [kbd_pkg::CODE_W-1:0] last_code_r, last_code_nxt;
  logic                       last_valid_r, last_valid_nxt;
  logic                       last_held_r, last_held_nxt;
  logic                       last_rep_r, last_rep_nxt;

  // Modifier refresh read after a configuration write
  logic                              ref_r, ref_nxt;
  logic [kbd_pkg::CFG_IDX_W-1:0]     ref_idx_r, ref_idx_nxt;
  logic                              ref_zero_r, ref_zero_nxt;

  logic                       ev;
  logic                       is_poll;
  logic                       rep;
  logic                       alt;
  logic                       ctrl;
  logic                       shift;
  logic [kbd_pkg::CODE_W-1:0] ch;
  logic                       give_char;

  assign ev      = acc && (item.op == kbd_pkg::OP_EVENT) && kbd_pkg::key_in_range(item.scancode);
  assign is_poll = acc && (item.op == kbd_pkg::OP_POLL);

  // Status toward the handshake
  assign status.clearing   = clr_busy_r;
  assign status.refreshing = ref_r;

  // Drive the held-map RAM: clear sweep first, then events
  always_comb begin
    ram_req = '0;
    if (clr_busy_r) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = clr_idx_r;
      ram_req.wdata = 1'b0;
    end else begin
      ram_req.we    = ev;
      ram_req.waddr = kbd_pkg::key_addr(item.scancode);
      ram_req.wdata = item.pressed;
    end
    ram_req.re    = acc || cfg_we;
    ram_req.raddr = cfg_we ? kbd_pkg::key_addr(cfg_val) : kbd_pkg::key_addr(item.scancode);
  end

  // Build the poll report from the last key and modifier flags
  assign rep       = last_valid_r && last_held_r && !last_rep_r;
  assign alt       = mod_held_r[kbd_pkg::CFG_ALT];
  assign ctrl      = mod_held_r[kbd_pkg::CFG_CTRL];
  assign shift     = mod_held_r[kbd_pkg::CFG_LSHIFT] || mod_held_r[kbd_pkg::CFG_RSHIFT];
  assign ch        = kbd_pkg::char_lookup(last_code_r, shift);
  assign give_char = !alt && !ctrl && (last_code_r != '0) && (ch != '0);

  always_comb begin
    poll_res = '0;
    if (rep) begin
      poll_res.key_valid = 1'b1;
      if (give_char) begin
        poll_res.is_char   = 1'b1;
        poll_res.char_code = ch;
      end else begin
        poll_res.key_code   = last_code_r;
        poll_res.alt_held   = alt;
        poll_res.ctrl_held  = ctrl;
        poll_res.shift_held = shift;
      end
    end
  end

  // Advance the clearing pass
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_idx_nxt  = clr_idx_r;
    if (clr_busy_r) begin
      clr_idx_nxt = clr_idx_r + kbd_pkg::KEY_ADDR_W'(1);
      if (clr_idx_r == kbd_pkg::KEY_ADDR_W'(kbd_pkg::KEY_COUNT - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  // Track the last pressed key and whether it was reported
  always_comb begin
    last_code_nxt  = last_code_r;
    last_valid_nxt = last_valid_r;
    last_held_nxt  = last_held_r;
    last_rep_nxt   = last_rep_r;
    if (ev && item.pressed) begin
      last_code_nxt  = item.scancode;
      last_valid_nxt = 1'b1;
      last_held_nxt  = 1'b1;
      last_rep_nxt   = 1'b0;
    end else if (ev && (item.scancode == last_code_r)) begin
      last_held_nxt = 1'b0;
    end
    if (is_poll && rep) begin
      last_rep_nxt = 1'b1;
    end
  end

  // Update modifier codes and flags, refresh a flag from the map after a write
  always_comb begin
    mod_code_nxt = mod_code_r;
    mod_held_nxt = mod_held_r;
    ref_nxt      = cfg_we;
    ref_idx_nxt  = cfg_idx;
    ref_zero_nxt = clr_busy_r || !kbd_pkg::key_in_range(cfg_val);
    for (int i = 0; i < kbd_pkg::MOD_COUNT; i++) begin
      if (ev && (item.scancode == mod_code_r[i])) begin
        mod_held_nxt[i] = item.pressed;
      end
    end
    if (ref_r) begin
      mod_held_nxt[ref_idx_r] = !ref_zero_r && rd_bit;
    end
    if (cfg_we) begin
      mod_code_nxt[cfg_idx] = cfg_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r   <= 1'b1;
      clr_idx_r    <= '0;
      mod_code_r   <= kbd_pkg::MOD_RESET;
      mod_held_r   <= '0;
      last_code_r  <= '0;
      last_valid_r <= 1'b0;
      last_held_r  <= 1'b0;
      last_rep_r   <= 1'b0;
      ref_r        <= 1'b0;
      ref_idx_r    <= '0;
      ref_zero_r   <= 1'b0;
    end else begin
      clr_busy_r   <= clr_busy_nxt;
      clr_idx_r    <= clr_idx_nxt;
      mod_code_r   <= mod_code_nxt;
      mod_held_r   <= mod_held_nxt;
      last_code_r  <= last_code_nxt;
      last_valid_r <= last_valid_nxt;
      last_held_r  <= last_held_nxt;
      last_rep_r   <= last_rep_nxt;
      ref_r        <= ref_nxt;
      ref_idx_r    <= ref_idx_nxt;
      ref_zero_r   <= ref_zero_nxt;
    end
  end

endmodule

// File: test/keyboard_scancode_decoder_core_tb.sv
`timescale 1ns / 1ps

module keyboard_scancode_decoder_core_tb;

  localparam logic [kbd_pkg::OP_W-1:0] OP_RESERVED = 2'd3;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASE_ITEMS  = 80;
  localparam int PRINT_CAP    = 100;

  // Register index of each modifier slot
  localparam logic [kbd_pkg::MOD_COUNT-1:0][kbd_pkg::CFG_IDX_W-1:0] MOD_REGS =
    {kbd_pkg::CFG_RSHIFT, kbd_pkg::CFG_LSHIFT, kbd_pkg::CFG_CTRL, kbd_pkg::CFG_ALT};

  // Character tables for codes below 64; higher codes have no character
  localparam logic [0:63][kbd_pkg::CODE_W-1:0] PLAIN_CHARS = {
    7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h00, 7'h00,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h00, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h5C, 7'h00, 7'h3C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam logic [0:63][kbd_pkg::CODE_W-1:0] SHIFTED_CHARS = {
    7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h00, 7'h00,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h00, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7C, 7'h00, 7'h3E, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // How a directed row gets its expected report
  typedef enum logic [1:0] {
    ROW_PREDICT = 2'd0,
    ROW_NONE    = 2'd1,
    ROW_DOWN    = 2'd2,
    ROW_CHAR    = 2'd3
  } row_check_t;

  typedef struct packed {
    logic [kbd_pkg::OP_W-1:0]   op;
    logic [kbd_pkg::CODE_W-1:0] code;
    logic                       pressed;
    row_check_t                 check;
    logic [kbd_pkg::CODE_W-1:0] ch;
  } stim_row_t;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  kbd_pkg::kbd_in_t              in_data   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  kbd_pkg::kbd_out_t             out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [kbd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [kbd_pkg::CODE_W-1:0]    cfg_data  = '0;

  // Predicted key state and modifier setup
  logic [kbd_pkg::KEY_COUNT-1:0] held_keys;
  logic [kbd_pkg::KEY_COUNT-1:0] reported_keys;
  logic [kbd_pkg::CODE_W-1:0]    last_key;
  logic                          last_key_seen;
  logic [kbd_pkg::CODE_W-1:0]    mod_code [kbd_pkg::MOD_COUNT];

  kbd_pkg::kbd_out_t pending_reports [$];
  stim_row_t         directed_rows [$];
  int                mismatch_count = 0;
  int                items_sent = 0;
  int unsigned       cycle_count = 0;
  bit                calm = 1'b0;

  keyboard_scancode_decoder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Decode one item against the key state and advance that state
  function automatic kbd_pkg::kbd_out_t decode_item(input kbd_pkg::kbd_in_t item);
    kbd_pkg::kbd_out_t          r;
    logic                       alt;
    logic                       ctrl;
    logic                       shift;
    logic [kbd_pkg::CODE_W-1:0] ch;
    r = '0;
    case (item.op)
      kbd_pkg::OP_EVENT: begin
        if (item.pressed) begin
          last_key = item.scancode;
          last_key_seen = 1'b1;
          held_keys[item.scancode] = 1'b1;
          reported_keys[item.scancode] = 1'b0;
        end else begin
          held_keys[item.scancode] = 1'b0;
        end
      end
      kbd_pkg::OP_TEST: r.key_is_down = held_keys[item.scancode];
      kbd_pkg::OP_POLL: begin
        if (last_key_seen && held_keys[last_key] && !reported_keys[last_key]) begin
          reported_keys[last_key] = 1'b1;
          r.key_valid = 1'b1;
          alt   = held_keys[mod_code[kbd_pkg::CFG_ALT]];
          ctrl  = held_keys[mod_code[kbd_pkg::CFG_CTRL]];
          shift = held_keys[mod_code[kbd_pkg::CFG_LSHIFT]] |
                  held_keys[mod_code[kbd_pkg::CFG_RSHIFT]];
          ch = '0;
          if (last_key < 64) begin
            ch = shift ? SHIFTED_CHARS[last_key[5:0]] : PLAIN_CHARS[last_key[5:0]];
          end
          // Scancode zero is kept from giving a character, so it always ends in a raw report
          if (!alt && !ctrl && last_key != 0 && ch != 0) begin
            r.is_char = 1'b1;
            r.char_code = ch;
          end else begin
            r.key_code = last_key;
            r.alt_held = alt;
            r.ctrl_held = ctrl;
            r.shift_held = shift;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      flag_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    end
  endtask

  task automatic compare_report(input kbd_pkg::kbd_out_t got, input kbd_pkg::kbd_out_t want);
    check_field("key_valid", got.key_valid, want.key_valid);
    check_field("is_char", got.is_char, want.is_char);
    check_field("char_code", got.char_code, want.char_code);
    check_field("key_code", got.key_code, want.key_code);
    check_field("alt_held", got.alt_held, want.alt_held);
    check_field("ctrl_held", got.ctrl_held, want.ctrl_held);
    check_field("shift_held", got.shift_held, want.shift_held);
    check_field("key_is_down", got.key_is_down, want.key_is_down);
  endtask

  task automatic add_row(input logic [kbd_pkg::OP_W-1:0] op,
                         input logic [kbd_pkg::CODE_W-1:0] code,
                         input logic pressed, input row_check_t check,
                         input logic [kbd_pkg::CODE_W-1:0] ch);
    stim_row_t row;
    row.op = op;
    row.code = code;
    row.pressed = pressed;
    row.check = check;
    row.ch = ch;
    directed_rows.push_back(row);
  endtask

  // Offer one item, hold it until taken, then record its expected report
  task automatic send_item(input logic [kbd_pkg::OP_W-1:0] op,
                           input logic [kbd_pkg::CODE_W-1:0] code,
                           input logic pressed, input row_check_t check,
                           input logic [kbd_pkg::CODE_W-1:0] ch);
    kbd_pkg::kbd_in_t  item;
    kbd_pkg::kbd_out_t predicted;
    kbd_pkg::kbd_out_t typed;
    item.op = op;
    item.scancode = code;
    item.pressed = pressed;
    while (!calm && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predicted = decode_item(item);
    typed = '0;
    case (check)
      ROW_DOWN: typed.key_is_down = 1'b1;
      ROW_CHAR: begin
        typed.key_valid = 1'b1;
        typed.is_char = 1'b1;
        typed.char_code = ch;
      end
      default: ;
    endcase
    pending_reports.push_back(check == ROW_PREDICT ? predicted : typed);
    items_sent++;
  endtask

  // Drop valid and hold off until every expected report has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // Write all four modifier registers back to back
  task automatic set_modifiers(input logic [kbd_pkg::CODE_W-1:0] alt,
                               input logic [kbd_pkg::CODE_W-1:0] ctrl,
                               input logic [kbd_pkg::CODE_W-1:0] lshift,
                               input logic [kbd_pkg::CODE_W-1:0] rshift);
    logic [kbd_pkg::MOD_COUNT-1:0][kbd_pkg::CODE_W-1:0] codes;
    codes = {rshift, lshift, ctrl, alt};
    for (int i = 0; i < kbd_pkg::MOD_COUNT; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= MOD_REGS[i];
      cfg_data <= codes[i];
      @(posedge clk);
      while (cfg_ready !== 1'b1) @(posedge clk);
      mod_code[MOD_REGS[i]] = codes[i];
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly keystrokes with random keys and modifiers, some raw noise
  task automatic random_phase(input int count);
    int                         stop_at;
    int                         slot;
    logic [kbd_pkg::CODE_W-1:0] key;
    logic [kbd_pkg::CODE_W-1:0] modifier;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 99) < 65) begin
        slot = $urandom_range(0, kbd_pkg::MOD_COUNT + 1);
        modifier = (slot < kbd_pkg::MOD_COUNT) ? mod_code[slot] : '0;
        key = ($urandom_range(0, 3) == 0) ? kbd_pkg::CODE_W'($urandom_range(0, 127)) :
                                            kbd_pkg::CODE_W'($urandom_range(1, 63));
        if (slot < kbd_pkg::MOD_COUNT) begin
          send_item(kbd_pkg::OP_EVENT, modifier, 1'b1, ROW_PREDICT, '0);
        end
        send_item(kbd_pkg::OP_EVENT, key, 1'b1, ROW_PREDICT, '0);
        send_item(kbd_pkg::OP_POLL, kbd_pkg::CODE_W'($urandom_range(0, 127)),
                  1'($urandom_range(0, 1)), ROW_PREDICT, '0);
        if ($urandom_range(0, 3) == 0) begin
          send_item(kbd_pkg::OP_POLL, kbd_pkg::CODE_W'($urandom_range(0, 127)),
                    1'($urandom_range(0, 1)), ROW_PREDICT, '0);
        end
        if ($urandom_range(0, 2) == 0) send_item(kbd_pkg::OP_TEST, key, 1'b0, ROW_PREDICT, '0);
        if ($urandom_range(0, 9) < 8) send_item(kbd_pkg::OP_EVENT, key, 1'b0, ROW_PREDICT, '0);
        if (slot < kbd_pkg::MOD_COUNT && $urandom_range(0, 9) < 7) begin
          send_item(kbd_pkg::OP_EVENT, modifier, 1'b0, ROW_PREDICT, '0);
        end
      end else begin
        send_item(kbd_pkg::OP_W'($urandom_range(0, 3)), kbd_pkg::CODE_W'($urandom_range(0, 127)),
                  1'($urandom_range(0, 1)), ROW_PREDICT, '0);
      end
    end
  endtask

  // Main sequence
  initial begin
    held_keys = '0;
    reported_keys = '0;
    last_key = '0;
    last_key_seen = 1'b0;
    mod_code[kbd_pkg::CFG_ALT] = 7'd56;
    mod_code[kbd_pkg::CFG_CTRL] = 7'd29;
    mod_code[kbd_pkg::CFG_LSHIFT] = 7'd42;
    mod_code[kbd_pkg::CFG_RSHIFT] = 7'd54;

    // Directed rows, run with the reset modifier setup
    add_row(kbd_pkg::OP_POLL,  7'd0,   1'b0, ROW_NONE,    7'h00);  // nothing pressed yet
    add_row(kbd_pkg::OP_TEST,  7'd0,   1'b0, ROW_NONE,    7'h00);
    add_row(kbd_pkg::OP_TEST,  7'd127, 1'b1, ROW_NONE,    7'h00);
    add_row(OP_RESERVED,       7'd127, 1'b1, ROW_NONE,    7'h00);  // unused op leaves state
    add_row(kbd_pkg::OP_EVENT, 7'd30,  1'b1, ROW_NONE,    7'h00);
    add_row(kbd_pkg::OP_POLL,  7'd0,   1'b0, ROW_CHAR,    7'h61);  // plain 'a'
    add_row(kbd_pkg::OP_POLL,  7'd127, 1'b1, ROW_NONE,    7'h00);  // already reported
    add_row(kbd_pkg::OP_TEST,  7'd30,  1'b0, ROW_DOWN,    7'h00);
    add_row(kbd_pkg::OP_EVENT, 7'd42,  1'b1, ROW_NONE,    7'h00);
    add_row(kbd_pkg::OP_POLL,  7'd0,   1'b0, ROW_PREDICT, 7'h00);  // shift key itself, raw
    add_row(kbd_pkg::OP_EVENT, 7'd30,  1'b1, ROW_NONE,    7'h00);
    add_row(kbd_pkg::OP_POLL,  7'd0,   1'b0, ROW_CHAR,    7'h41);  // shifted 'A'
    add_row(kbd_pkg::OP_EVENT, 7'd42,  1'b0, ROW_NONE,    7'h00);
    add_row(kbd_pkg::OP_EVENT, 7'd0,   1'b1, ROW_NONE,    7'h00);
    add_row(kbd_pkg::OP_POLL,  7'd0,   1'b0, ROW_PREDICT, 7'h00);  // scancode zero, raw
    add_row(kbd_pkg::OP_EVENT, 7'd29,  1'b1, ROW_NONE,    7'h00);
    add_row(kbd_pkg::OP_EVENT, 7'd127, 1'b1, ROW_NONE,    7'h00);
    add_row(kbd_pkg::OP_POLL,  7'd0,   1'b0, ROW_PREDICT, 7'h00);  // top code with ctrl
    add_row(kbd_pkg::OP_EVENT, 7'd29,  1'b0, ROW_NONE,    7'h00);
    add_row(kbd_pkg::OP_EVENT, 7'd54,  1'b1, ROW_NONE,    7'h00);
    add_row(kbd_pkg::OP_EVENT, 7'd53,  1'b1, ROW_NONE,    7'h00);
    add_row(kbd_pkg::OP_POLL,  7'd0,   1'b0, ROW_CHAR,    7'h3F);  // right shift, '?'
    add_row(kbd_pkg::OP_EVENT, 7'd56,  1'b1, ROW_NONE,    7'h00);
    add_row(kbd_pkg::OP_EVENT, 7'd16,  1'b1, ROW_NONE,    7'h00);
    add_row(kbd_pkg::OP_POLL,  7'd0,   1'b0, ROW_PREDICT, 7'h00);  // alt forces raw
    add_row(kbd_pkg::OP_TEST,  7'd56,  1'b0, ROW_DOWN,    7'h00);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].code, directed_rows[i].pressed,
                directed_rows[i].check, directed_rows[i].ch);
    end

    // Random phases, each under its own modifier setup
    wait_idle();
    set_modifiers(7'd56, 7'd29, 7'd42, 7'd54);
    random_phase(PHASE_ITEMS);
    wait_idle();
    set_modifiers(7'd0, 7'd127, 7'd0, 7'd127);
    random_phase(PHASE_ITEMS);
    wait_idle();
    set_modifiers(7'd127, 7'd0, 7'd127, 7'd0);
    calm = 1'b1;
    random_phase(PHASE_ITEMS);
    calm = 1'b0;
    wait_idle();
    set_modifiers(kbd_pkg::CODE_W'($urandom_range(0, 127)),
                  kbd_pkg::CODE_W'($urandom_range(0, 127)),
                  kbd_pkg::CODE_W'($urandom_range(0, 127)),
                  kbd_pkg::CODE_W'($urandom_range(0, 127)));
    random_phase(PHASE_ITEMS);
    wait_idle();
    set_modifiers(kbd_pkg::CODE_W'($urandom_range(0, 63)),
                  kbd_pkg::CODE_W'($urandom_range(0, 63)),
                  kbd_pkg::CODE_W'($urandom_range(0, 63)),
                  kbd_pkg::CODE_W'($urandom_range(0, 63)));
    random_phase(PHASE_ITEMS);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Stall the result side at random, except during the calm stretch
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 24);
  end

  // Check each accepted report against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch("report arrived with none expected");
      end else begin
        compare_report(out_data, pending_reports.pop_front());
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule
